>>> rtl/core/imm_pkg.sv
// Package for the integer matrix multiply core: widths, codes, state
// encoding and the command/status structs shared by controller and datapath.
// No dependencies.
`default_nettype none

package imm_pkg;

	localparam int IDX_W      = 3;
	localparam int MAX_DIM    = 1 << IDX_W;
	localparam int ADDR_W     = 2 * IDX_W;
	localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
	localparam int DIM_W      = 4;
	localparam int DATA_W     = 32;
	localparam int KIND_W     = 2;
	localparam int CFG_IDX_W  = 2;

	localparam int FIELD_W    = 2 * IDX_W + DATA_W;
	localparam int TDATA_W    = ((FIELD_W + 7) / 8) * 8;
	localparam int PAD_W      = TDATA_W - FIELD_W;

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD_A  = 2'd0,
		KIND_LOAD_B  = 2'd1,
		KIND_COMPUTE = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS_A    = 2'd0,
		REG_INNER_DIM = 2'd1,
		REG_COLS_B    = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_ISSUE = 2'd1,
		ST_WAIT  = 2'd2
	} state_t;

	typedef struct packed {
		logic             we_a;
		logic             we_b;
		logic             beat;
		logic             first;
		logic             lastk;
		logic             zero;
		logic             elem_last;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [IDX_W-1:0] k;
	} cmd_t;

	typedef struct packed {
		logic out_taken;
	} status_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
		logic [DIM_W-1:0] lim;
		lim = DIM_W'(MAX_DIM);
		return (d > lim) ? lim : d;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/integer_matrix_multiply_core.sv
// Integer matrix multiply core: C = A x B over two 8x8 element stores.
// Depends on imm_pkg, imm_ctrl and imm_dp (which holds two imm_ram stores).
//
// Input channel (s_*): one beat per item. tuser carries the kind: load an
// element of A, load an element of B, or compute. A load writes its value at
// (row, col); kind 3 is dropped. A compute beat starts a
// run that emits rows_a * cols_b product beats in row-major order on the
// output channel (m_*), m_tlast set on the final beat. Runs with zero rows or
// zero columns emit nothing; dimensions above 8 act as 8.
// Each product element issues max(inner_dim, 1) store reads through the
// single read port of each store, then passes through the read, multiply
// and accumulate registers before its beat is presented; the next element
// is started once that beat is taken. s_tready is low for the whole run.
// When the receiver stalls, the beat is held in the output register and the
// element walk waits.
// Configuration (cfg_*): index 0 rows_a, 1 inner_dim, 2 cols_b; always ready.
// The user must write it only while no run is active; the block does not enforce this.
// Reset clears the control state and sets all three dimensions to 8; store
// contents are undefined until loaded.
`default_nettype none

module integer_matrix_multiply_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// [2:0] row, [5:3] col, [37:6] value, upper bits zero
	input  wire logic [imm_pkg::TDATA_W-1:0]   s_tdata,
	// [1:0] kind
	input  wire logic [imm_pkg::KIND_W-1:0]    s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// [2:0] out_row, [5:3] out_col, [37:6] product, upper bits zero
	output logic [imm_pkg::TDATA_W-1:0]        m_tdata,
	output logic                               m_tlast,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [imm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [imm_pkg::DIM_W-1:0]     cfg_data
);

	import imm_pkg::*;

	cmd_t              cmd;
	status_t           status;
	logic [IDX_W-1:0]  in_row, in_col, out_row, out_col;
	logic [DATA_W-1:0] in_value, product;

	assign in_row   = s_tdata[IDX_W-1:0];
	assign in_col   = s_tdata[2*IDX_W-1:IDX_W];
	assign in_value = s_tdata[FIELD_W-1:2*IDX_W];

	imm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.kind      (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.status    (status),
		.cmd       (cmd)
	);

	imm_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_row   (in_row),
		.in_col   (in_col),
		.in_value (in_value),
		.cmd      (cmd),
		.status   (status),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.out_row  (out_row),
		.out_col  (out_col),
		.product  (product),
		.last     (m_tlast)
	);

	assign m_tdata = {{PAD_W{1'b0}}, product, out_col, out_row};

endmodule

`default_nettype wire

>>> rtl/core/imm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module imm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/core/imm_ctrl.sv
// Controller: configuration registers, input acceptance and the i/j/k walk
// that sequences the datapath. Depends on imm_pkg.
`default_nettype none

module imm_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [imm_pkg::KIND_W-1:0]    kind,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [imm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [imm_pkg::DIM_W-1:0]     cfg_data,
	input  wire imm_pkg::status_t              status,
	output imm_pkg::cmd_t                      cmd
);

	import imm_pkg::*;

	state_t           st_q, st_next;
	logic [DIM_W-1:0] rows_a_q, inner_dim_q, cols_b_q;
	logic [DIM_W-1:0] nr, nk, nc;
	logic [IDX_W-1:0] i_q, j_q, k_q;
	logic             row_end, col_end, k_end, nk_zero, start;

	assign nr = clamp_dim(rows_a_q);
	assign nk = clamp_dim(inner_dim_q);
	assign nc = clamp_dim(cols_b_q);

	assign row_end = DIM_W'(i_q) == nr - DIM_W'(1);
	assign col_end = DIM_W'(j_q) == nc - DIM_W'(1);
	assign nk_zero = nk == '0;
	assign k_end   = nk_zero || (DIM_W'(k_q) == nk - DIM_W'(1));
	assign start   = s_tvalid && s_tready && (kind_t'(kind) == KIND_COMPUTE)
		&& (nr != '0) && (nc != '0);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q    <= DIM_W'(MAX_DIM);
			inner_dim_q <= DIM_W'(MAX_DIM);
			cols_b_q    <= DIM_W'(MAX_DIM);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_ROWS_A:    rows_a_q    <= cfg_data;
				REG_INNER_DIM: inner_dim_q <= cfg_data;
				REG_COLS_B:    cols_b_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			i_q  <= '0;
			j_q  <= '0;
			k_q  <= '0;
		end else begin
			st_q <= st_next;
			if (start) begin
				i_q <= '0;
				j_q <= '0;
				k_q <= '0;
			end else if (st_q == ST_ISSUE) begin
				k_q <= k_end ? '0 : k_q + IDX_W'(1);
			end else if (st_q == ST_WAIT && status.out_taken) begin
				if (col_end) begin
					j_q <= '0;
					i_q <= i_q + IDX_W'(1);
				end else begin
					j_q <= j_q + IDX_W'(1);
				end
			end
		end
	end

	always_comb begin
		st_next  = st_q;
		s_tready = 1'b0;
		cmd      = '0;
		cmd.row  = i_q;
		cmd.col  = j_q;
		cmd.k    = k_q;
		case (st_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					case (kind_t'(kind))
						KIND_LOAD_A: cmd.we_a = 1'b1;
						KIND_LOAD_B: cmd.we_b = 1'b1;
						KIND_COMPUTE: begin
							if ((nr != '0) && (nc != '0)) begin
								st_next = ST_ISSUE;
							end
						end
						default: ;
					endcase
				end
			end
			ST_ISSUE: begin
				cmd.beat      = 1'b1;
				cmd.first     = k_q == '0;
				cmd.zero      = nk_zero;
				cmd.lastk     = k_end;
				cmd.elem_last = row_end && col_end;
				if (k_end) begin
					st_next = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (status.out_taken) begin
					st_next = (row_end && col_end) ? ST_IDLE : ST_ISSUE;
				end
			end
			default: st_next = ST_IDLE;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.beat |-> !s_tready && !cmd.we_a && !cmd.we_b)
		else $error("beat issued while loads are accepted");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_ISSUE) && k_end |=> (st_q == ST_WAIT) && (k_q == '0))
		else $error("inner walk did not close on its last beat");
	assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (st_q == ST_ISSUE) && (i_q == '0) && (j_q == '0))
		else $error("compute run did not start at the first element");

endmodule

`default_nettype wire

>>> rtl/core/imm_dp.sv
// Datapath: A and B element stores, multiply stage, accumulator and the
// output register. Depends on imm_pkg and imm_ram.
`default_nettype none

module imm_dp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [imm_pkg::IDX_W-1:0]   in_row,
	input  wire logic [imm_pkg::IDX_W-1:0]   in_col,
	input  wire logic [imm_pkg::DATA_W-1:0]  in_value,
	input  wire imm_pkg::cmd_t               cmd,
	output imm_pkg::status_t                 status,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [imm_pkg::IDX_W-1:0]        out_row,
	output logic [imm_pkg::IDX_W-1:0]        out_col,
	output logic [imm_pkg::DATA_W-1:0]       product,
	output logic                             last
);

	import imm_pkg::*;

	logic [ADDR_W-1:0] waddr, raddr_a, raddr_b;
	logic [DATA_W-1:0] a_s1, b_s1, mul_c, mul_s2, acc_q, acc_sum;
	logic              valid_s1, first_s1, lastk_s1, zero_s1, elast_s1;
	logic              valid_s2, first_s2, lastk_s2, zero_s2, elast_s2;
	logic [IDX_W-1:0]  row_s1, col_s1, row_s2, col_s2;
	logic              m_tvalid_q, last_q;
	logic [IDX_W-1:0]  out_row_q, out_col_q;
	logic [DATA_W-1:0] out_product_q;

	assign waddr   = {in_row, in_col};
	assign raddr_a = {cmd.row, cmd.k};
	assign raddr_b = {cmd.k, cmd.col};

	imm_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_store_a (
		.clk   (clk),
		.we    (cmd.we_a),
		.waddr (waddr),
		.wdata (in_value),
		.raddr (raddr_a),
		.rdata (a_s1)
	);

	imm_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_store_b (
		.clk   (clk),
		.we    (cmd.we_b),
		.waddr (waddr),
		.wdata (in_value),
		.raddr (raddr_b),
		.rdata (b_s1)
	);

	assign mul_c   = zero_s1 ? '0 : a_s1 * b_s1;
	assign acc_sum = (first_s2 ? '0 : acc_q) + mul_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			valid_s1 <= cmd.beat;
			valid_s2 <= valid_s1;
			if (valid_s2 && lastk_s2) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= cmd.first;
		lastk_s1 <= cmd.lastk;
		zero_s1  <= cmd.zero;
		elast_s1 <= cmd.elem_last;
		row_s1   <= cmd.row;
		col_s1   <= cmd.col;
		mul_s2   <= mul_c;
		first_s2 <= first_s1;
		lastk_s2 <= lastk_s1;
		zero_s2  <= zero_s1;
		elast_s2 <= elast_s1;
		row_s2   <= row_s1;
		col_s2   <= col_s1;
		if (valid_s2) begin
			acc_q <= acc_sum;
		end
		if (valid_s2 && lastk_s2) begin
			out_product_q <= acc_sum;
			out_row_q     <= row_s2;
			out_col_q     <= col_s2;
			last_q        <= elast_s2;
		end
	end

	assign m_tvalid         = m_tvalid_q;
	assign out_row          = out_row_q;
	assign out_col          = out_col_q;
	assign product          = out_product_q;
	assign last             = last_q;
	assign status.out_taken = m_tvalid_q && m_tready;

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && lastk_s2 |-> !m_tvalid_q)
		else $error("result overwrites an undelivered beat");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> !valid_s1 && !valid_s2)
		else $error("pipeline busy while a result waits");
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && zero_s2 |-> first_s2 && lastk_s2)
		else $error("empty inner sum spans more than one beat");

endmodule

`default_nettype wire
